// ===== rtl/ppd_pkg.sv =====
package ppd_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF = 8;
	localparam int MAX_INTERMEDIATE_DEF = 62;

	localparam int CFG_WIDTH = 16;
	localparam int IDX_WIDTH = 16;
	localparam logic [CFG_WIDTH-1:0] GAP_THRESHOLD_RST = 16'd1536;
	localparam logic [CFG_WIDTH-1:0] SPACING_RST = 16'd1024;

	// register index, taken from paddr[2]
	localparam logic REG_GAP_THRESHOLD = 1'b0;
	localparam logic REG_SPACING = 1'b1;

endpackage

// ===== rtl/ppd_div.sv =====
module ppd_div #(
	parameter int NUM_BITS = 40,
	parameter int DEN_BITS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_BITS-1:0]        num,
	input  logic [DEN_BITS-1:0]        den,
	output logic                       done,
	output logic [NUM_BITS-1:0]        quot,
	output logic [DEN_BITS-1:0]        rem
);

	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] q_q;
	logic [DEN_BITS:0]   r_q;
	logic [DEN_BITS-1:0] d_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS+1:0] diff;

	assign trial = {r_q[DEN_BITS-1:0], q_q[NUM_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_BITS+1]) begin
				r_q <= diff[DEN_BITS:0];
				q_q <= {q_q[NUM_BITS-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q[DEN_BITS-1:0];

endmodule

// ===== rtl/polyline_point_densifier_unit.sv =====
// Polyline point densifier. Each accepted point (s_axis) is compared with the
// previous one; the previous point is emitted, then n-1 evenly spaced
// intermediates when the gap exceeds gap_threshold (n = floor(gap/spacing),
// capped at MAX_INTERMEDIATE), then the point itself if tlast marks it final.
// One shared multiplier squares the deltas and the threshold, tests k*spacing
// candidates (up to MAX_INTERMEDIATE of them) and forms i*delta, and one
// restoring divider serves all three axes per intermediate. s_axis_tready
// is low for the whole of a point's work, output stalls included.
module polyline_point_densifier_unit
	import ppd_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_INTERMEDIATE = MAX_INTERMEDIATE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata, // pos_x, pos_y, pos_z
	input  logic                          s_axis_tlast,  // final_point
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [((3*COORD_BITS+IDX_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// out_x, out_y, out_z, point_index
	output logic                          m_axis_tlast,  // run_end
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int CB = COORD_BITS;
	localparam int DB = CB + 1;              // delta width
	localparam int KW = $clog2(MAX_INTERMEDIATE + 1);
	localparam int PW = DB + KW;             // i*delta width (signed)
	localparam int SQW = 2 * DB;
	localparam int SUMW = SQW + 2;
	localparam int MW = (DB > KW + CFG_WIDTH) ? DB : KW + CFG_WIDTH;
	localparam int CMPW = (2 * MW > SUMW) ? 2 * MW : SUMW;
	localparam int OW = ((3*CB+IDX_WIDTH+7)/8)*8;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ   = 4'd1;
	localparam logic [3:0] ST_THR  = 4'd2;
	localparam logic [3:0] ST_KMUL = 4'd3;
	localparam logic [3:0] ST_KSQ  = 4'd4;
	localparam logic [3:0] ST_EPRV = 4'd5;
	localparam logic [3:0] ST_IMUL = 4'd6;
	localparam logic [3:0] ST_IDIV = 4'd7;
	localparam logic [3:0] ST_IWT  = 4'd8;
	localparam logic [3:0] ST_EINT = 4'd9;
	localparam logic [3:0] ST_EFIN = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] st_q;
	logic [CFG_WIDTH-1:0] gap_q, spc_q;
	logic signed [CB-1:0] px_q, py_q, pz_q, cx_q, cy_q, cz_q;
	logic signed [DB-1:0] d_q [3];
	logic have_q, fin_q;
	logic [IDX_WIDTH-1:0] cnt_q;
	logic [1:0] ax_q;
	logic [SUMW-1:0] sum_q;
	logic [KW-1:0] k_q, n_q, i_q;
	logic [MW-1:0] len_q;
	logic signed [CB-1:0] ix_q [3];
	logic signed [PW-1:0] prod_q;

	// shared multiplier
	logic [MW-1:0] ma, mb;
	logic [2*MW-1:0] mp;
	assign mp = ma * mb;

	logic [DB-1:0] dabs;
	assign dabs = d_q[ax_q][DB-1] ? DB'(-d_q[ax_q]) : d_q[ax_q];

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_SQ: begin
				ma = MW'(dabs);
				mb = MW'(dabs);
			end
			ST_THR: begin
				ma = MW'(gap_q);
				mb = MW'(gap_q);
			end
			ST_KMUL: begin
				ma = MW'(k_q);
				mb = MW'(spc_q);
			end
			ST_KSQ: begin
				ma = len_q;
				mb = len_q;
			end
			ST_IMUL: begin
				ma = MW'(i_q);
				mb = MW'(dabs);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// divider on magnitude of i*delta
	logic div_start, div_done;
	logic [PW-1:0] div_num, div_quot;
	logic [KW-1:0] div_rem;
	logic neg_q;

	ppd_div #(.NUM_BITS(PW), .DEN_BITS(KW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(n_q), .done(div_done), .quot(div_quot), .rem(div_rem)
	);
	assign div_num = prod_q[PW-1:0];

	logic signed [PW:0] fq;
	always_comb begin
		if (neg_q)
			fq = -$signed({1'b0, div_quot}) - $signed({{PW{1'b0}}, (div_rem != '0)});
		else
			fq = $signed({1'b0, div_quot});
	end

	logic signed [CB-1:0] pax;
	assign pax = (ax_q == 2'd0) ? px_q : (ax_q == 2'd1) ? py_q : pz_q;

	// output register
	logic ov_q, ol_q;
	logic signed [CB-1:0] ox_q, oy_q, oz_q;
	logic [IDX_WIDTH-1:0] oi_q;
	logic [IDX_WIDTH-1:0] nxt_cnt;
	assign nxt_cnt = (cnt_q == '1) ? IDX_WIDTH'(1) : cnt_q + 1'b1;
	logic emit_st, can_emit, emit_go;
	assign emit_st = (st_q == ST_EPRV) || (st_q == ST_EINT) || (st_q == ST_EFIN);
	assign can_emit = !ov_q || m_axis_tready;
	assign emit_go = emit_st && can_emit;

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast = ol_q;
	assign m_axis_tdata = OW'({oi_q, oz_q, oy_q, ox_q});
	assign s_axis_tready = (st_q == ST_IDLE);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign div_start = (st_q == ST_IDIV);

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_comb begin
		unique case (paddr[2])
			REG_GAP_THRESHOLD: prdata = 32'(gap_q);
			REG_SPACING:       prdata = 32'(spc_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_THRESHOLD_RST;
			spc_q <= SPACING_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_GAP_THRESHOLD) gap_q <= pwdata[CFG_WIDTH-1:0];
			if (paddr[2] == REG_SPACING)       spc_q <= pwdata[CFG_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			have_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			fin_q <= 1'b0;
			d_q <= '{default: '0};
			ax_q <= '0;
			sum_q <= '0;
			k_q <= '0;
			n_q <= '0;
			i_q <= '0;
			len_q <= '0;
			ix_q <= '{default: '0};
			prod_q <= '0;
			neg_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
			oi_q <= '0;
			ol_q <= 1'b0;
		end else begin
			ov_q <= emit_go || (ov_q && !m_axis_tready);
			unique case (st_q)
				ST_IDLE: if (s_acc) begin
					cx_q <= s_axis_tdata[CB-1:0];
					cy_q <= s_axis_tdata[2*CB-1:CB];
					cz_q <= s_axis_tdata[3*CB-1:2*CB];
					fin_q <= s_axis_tlast;
					d_q[0] <= DB'($signed(s_axis_tdata[CB-1:0])) - DB'(px_q);
					d_q[1] <= DB'($signed(s_axis_tdata[2*CB-1:CB])) - DB'(py_q);
					d_q[2] <= DB'($signed(s_axis_tdata[3*CB-1:2*CB])) - DB'(pz_q);
					ax_q <= 2'd0;
					sum_q <= '0;
					if (!have_q) begin
						if (s_axis_tlast) st_q <= ST_EFIN;
						else begin
							px_q <= s_axis_tdata[CB-1:0];
							py_q <= s_axis_tdata[2*CB-1:CB];
							pz_q <= s_axis_tdata[3*CB-1:2*CB];
							have_q <= 1'b1;
						end
					end else st_q <= ST_SQ;
				end
				ST_SQ: begin
					sum_q <= sum_q + SUMW'(mp[SQW-1:0]);
					if (ax_q == 2'd2) st_q <= ST_THR;
					ax_q <= ax_q + 1'b1;
				end
				ST_THR: begin
					n_q <= '0;
					k_q <= KW'(MAX_INTERMEDIATE);
					st_q <= (sum_q > SUMW'(mp[2*CFG_WIDTH-1:0])) ? ST_KMUL : ST_EPRV;
				end
				ST_KMUL: begin
					len_q <= MW'(mp[KW+CFG_WIDTH-1:0]);
					st_q <= ST_KSQ;
				end
				ST_KSQ: begin
					if (CMPW'(mp) <= CMPW'(sum_q)) begin
						n_q <= k_q;
						st_q <= ST_EPRV;
					end else if (k_q == KW'(1)) st_q <= ST_EPRV;
					else begin
						k_q <= k_q - 1'b1;
						st_q <= ST_KMUL;
					end
				end
				ST_EPRV: if (can_emit) begin
					ox_q <= px_q;
					oy_q <= py_q;
					oz_q <= pz_q;
					ol_q <= 1'b0;
					oi_q <= nxt_cnt;
					cnt_q <= nxt_cnt;
					i_q <= KW'(1);
					ax_q <= 2'd0;
					st_q <= (n_q > KW'(1)) ? ST_IMUL : ST_DONE;
				end
				ST_IMUL: begin
					prod_q <= PW'(mp[PW-1:0]);
					neg_q <= d_q[ax_q][DB-1];
					st_q <= ST_IDIV;
				end
				ST_IDIV: st_q <= ST_IWT;
				ST_IWT: if (div_done) begin
					ix_q[ax_q] <= CB'(pax + CB'(fq));
					if (ax_q == 2'd2) begin
						ax_q <= 2'd0;
						st_q <= ST_EINT;
					end else begin
						ax_q <= ax_q + 1'b1;
						st_q <= ST_IMUL;
					end
				end
				ST_EINT: if (can_emit) begin
					ox_q <= ix_q[0];
					oy_q <= ix_q[1];
					oz_q <= ix_q[2];
					ol_q <= 1'b0;
					oi_q <= nxt_cnt;
					cnt_q <= nxt_cnt;
					i_q <= i_q + 1'b1;
					st_q <= (i_q + 1'b1 == n_q) ? ST_DONE : ST_IMUL;
				end
				ST_DONE: begin
					if (fin_q) st_q <= ST_EFIN;
					else begin
						px_q <= cx_q;
						py_q <= cy_q;
						pz_q <= cz_q;
						st_q <= ST_IDLE;
					end
				end
				ST_EFIN: if (can_emit) begin
					ox_q <= cx_q;
					oy_q <= cy_q;
					oz_q <= cz_q;
					ol_q <= 1'b1;
					oi_q <= nxt_cnt;
					cnt_q <= nxt_cnt;
					have_q <= 1'b0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
